[src/keyed_sidetone_oscillator_macros.svh]
// Assertion macros shared by the checker of the keyed sidetone oscillator.
// Depends on nothing; included by the checker file by its bare name.
`ifndef KEYED_SIDETONE_OSCILLATOR_MACROS_SVH
`define KEYED_SIDETONE_OSCILLATOR_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
// The enclosing module provides clk_i and rst_ni.
`define KSO_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed sidetone oscillator check failed");

// Consequent must hold in the same cycle as the antecedent.
`define KSO_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyed sidetone oscillator check failed");

`endif

[src/kso_pkg.sv]
// Package of the keyed sidetone oscillator: widths, codes, enums and the
// quarter-wave sine table built at elaboration. Depends on nothing.
package kso_pkg;

  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned TABLE_BITS = 10;
  localparam int unsigned ROM_DEPTH  = 1 << TABLE_BITS;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned VOL_W      = 16;
  localparam int unsigned ENV_W      = 6;
  localparam int unsigned FADE_LEN   = 48;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 19;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned M_W     = (SAMPLE_W - 1) + VOL_W + ENV_W;

  // Division by FADE_LEN * 2^15 is a shift by 19 (2^15 * 16) then a
  // multiplication by the reciprocal of three, exact below 2^19.
  localparam int unsigned QUOT_SHIFT  = 19;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned Q_W         = 18;
  localparam logic [M_W:0]       ROUND_HALF = (M_W + 1)'((FADE_LEN << 15) / 2);
  localparam logic [MUL_B_W-1:0] RECIP3     = MUL_B_W'(((1 << RECIP_SHIFT) + 2) / 3);

  localparam logic [SAMPLE_W-1:0] MAG_MAX = 16'd32767;
  localparam logic [Q_W-1:0]      POS_MAX = 18'd32767;
  localparam logic [Q_W-1:0]      NEG_MAX = 18'd32768;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    FADE_IDLE = 2'd0,
    FADE_IN   = 2'd1,
    FADE_FULL = 2'd2,
    FADE_DOWN = 2'd3
  } fade_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ENV,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_VOLUME     = 2'd1,
    CFG_ENABLE     = 2'd2
  } cfg_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_KEY    = 1'b1
  } cmd_e;

  typedef logic [SAMPLE_W-1:0] rom_t [ROM_DEPTH];

  // Entry k is round(32767 * sin(pi/2 * k / ROM_DEPTH)) from a Q30 Taylor series.
  function automatic rom_t gen_sine_rom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    for (int unsigned k = 0; k < ROM_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int unsigned n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      rom[TABLE_BITS'(k)] = (v > 64'd32767) ? MAG_MAX : v[SAMPLE_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = gen_sine_rom();

endpackage

[src/keyed_sidetone_oscillator.sv]
// Keyed sidetone oscillator: phase accumulator, quarter-wave sine lookup,
// keying envelope and one shared multiplier under a small sequencer.
// Depends on kso_pkg.
//
// Input beats carry a kind in s_axis_tuser: a sample tick or a key event.
// A key event updates the key in the cycle it is taken and yields no beat.
// A sample tick yields one output beat: the sine sample scaled by volume
// and envelope in m_axis_tdata, the active flag in m_axis_tuser.
// A sample tick runs through the table read on acceptance, then three passes
// through the shared multiplier (volume, envelope, reciprocal of the fade
// length) and a step that loads the output register. The input is not ready
// until that load, so a new sample waits until the last one is through.
// The result waits in the output register while the receiver stalls; the
// next item is taken meanwhile, and a following sample holds in its last
// step until the register frees up.
// Configuration writes are taken every cycle and must only happen while the
// block is idle. Reset clears the configuration, the phase, the key, the
// envelope and the sequencer; the output beat is empty after reset.
module keyed_sidetone_oscillator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [0] key_on
  input  logic [0:0]                       s_axis_tuser,   // [0] cmd
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,   // [15:0] sample_out
  output logic [0:0]                       m_axis_tuser,   // [0] active
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [kso_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kso_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [kso_pkg::PHASE_W-1:0]    phase_step_q;
  logic [kso_pkg::VOL_W-1:0]      volume_q;
  logic                           enable_q;

  logic [kso_pkg::PHASE_W-1:0]    phase_acc_q, phase_acc_d;
  kso_pkg::fade_e                 fade_mode_q, fade_mode_d;
  logic [kso_pkg::ENV_W-1:0]      fade_count_q, fade_count_d, count_inc;
  logic                           keyed_q, keyed_d;
  logic [kso_pkg::ENV_W-1:0]      env_d, env_q;

  kso_pkg::state_e                state_q, state_d;

  logic [kso_pkg::SAMPLE_W-1:0]   rom_q;
  logic                           force_max_q;
  logic                           neg_q;
  logic                           active_q;

  logic [kso_pkg::TABLE_BITS-1:0] idx;
  logic [kso_pkg::TABLE_BITS-1:0] rom_addr;
  logic [1:0]                     quadrant;
  logic                           force_max;

  logic [kso_pkg::SAMPLE_W-1:0]   mag;
  logic [kso_pkg::MUL_A_W-1:0]    mul_a;
  logic [kso_pkg::MUL_B_W-1:0]    mul_b;
  logic [kso_pkg::PROD_W-1:0]     prod_d, prod_q;
  logic                           prod_load;
  logic [kso_pkg::M_W:0]          rounded;
  logic [kso_pkg::MUL_B_W-1:0]    quot_in;

  logic [kso_pkg::Q_W-1:0]        q;
  logic [kso_pkg::Q_W-1:0]        q_sat;
  logic [kso_pkg::SAMPLE_W-1:0]   res;

  logic                           in_fire, sample_fire, key_fire, key_in;
  logic                           out_load;
  logic                           out_valid_q;
  logic [kso_pkg::SAMPLE_W-1:0]   out_data_q;
  logic                           out_active_q;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign sample_fire = in_fire && (s_axis_tuser[0] == kso_pkg::CMD_SAMPLE);
  assign key_fire    = in_fire && (s_axis_tuser[0] == kso_pkg::CMD_KEY);
  assign key_in      = s_axis_tdata[0];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= '0;
      volume_q     <= '0;
      enable_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        kso_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data_i[kso_pkg::PHASE_W-1:0];
        kso_pkg::CFG_VOLUME:     volume_q     <= cfg_data_i[kso_pkg::VOL_W-1:0];
        kso_pkg::CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign quadrant  = phase_acc_q[kso_pkg::PHASE_W-1 -: 2];
  assign idx       = phase_acc_q[kso_pkg::PHASE_W-3 -: kso_pkg::TABLE_BITS];
  assign rom_addr  = quadrant[0] ? (kso_pkg::TABLE_BITS'(0) - idx) : idx;
  assign force_max = quadrant[0] && (idx == '0);
  assign count_inc = fade_count_q + kso_pkg::ENV_W'(1);

  always_comb begin
    phase_acc_d  = phase_acc_q;
    fade_mode_d  = fade_mode_q;
    fade_count_d = fade_count_q;
    keyed_d      = keyed_q;
    env_d        = '0;
    if (key_fire) begin
      if (key_in != keyed_q) begin
        keyed_d      = key_in;
        fade_mode_d  = key_in ? kso_pkg::FADE_IN : kso_pkg::FADE_DOWN;
        fade_count_d = '0;
        if (key_in) begin
          phase_acc_d = '0;
        end
      end
    end else if (sample_fire) begin
      phase_acc_d = phase_acc_q + phase_step_q;
      case (fade_mode_q)
        kso_pkg::FADE_IN: begin
          env_d        = fade_count_q;
          fade_count_d = count_inc;
          if (count_inc >= kso_pkg::ENV_W'(kso_pkg::FADE_LEN)) begin
            fade_mode_d = kso_pkg::FADE_FULL;
          end
        end
        kso_pkg::FADE_DOWN: begin
          env_d = (fade_count_q < kso_pkg::ENV_W'(kso_pkg::FADE_LEN)) ?
                  kso_pkg::ENV_W'(kso_pkg::FADE_LEN) - fade_count_q : '0;
          fade_count_d = count_inc;
          if (count_inc >= kso_pkg::ENV_W'(kso_pkg::FADE_LEN)) begin
            fade_mode_d = kso_pkg::FADE_IDLE;
            env_d       = '0;
          end
        end
        kso_pkg::FADE_FULL: env_d = kso_pkg::ENV_W'(kso_pkg::FADE_LEN);
        default:            env_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q  <= '0;
      fade_mode_q  <= kso_pkg::FADE_IDLE;
      fade_count_q <= '0;
      keyed_q      <= 1'b0;
    end else begin
      phase_acc_q  <= phase_acc_d;
      fade_mode_q  <= fade_mode_d;
      fade_count_q <= fade_count_d;
      keyed_q      <= keyed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_fire) begin
      rom_q       <= kso_pkg::SINE_ROM[rom_addr];
      force_max_q <= force_max;
      neg_q       <= quadrant[1];
      active_q    <= keyed_q && enable_q;
      env_q       <= env_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kso_pkg::ST_IDLE:  if (sample_fire) state_d = kso_pkg::ST_SCALE;
      kso_pkg::ST_SCALE: state_d = kso_pkg::ST_ENV;
      kso_pkg::ST_ENV:   state_d = kso_pkg::ST_DIV;
      kso_pkg::ST_DIV:   state_d = kso_pkg::ST_OUT;
      kso_pkg::ST_OUT:   if (!out_valid_q || m_axis_tready) state_d = kso_pkg::ST_IDLE;
      default:           state_d = kso_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kso_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign mag     = force_max_q ? kso_pkg::MAG_MAX : rom_q;
  assign rounded = prod_q[kso_pkg::M_W-1:0] + kso_pkg::ROUND_HALF;
  assign quot_in = rounded[kso_pkg::QUOT_SHIFT +: kso_pkg::MUL_B_W];

  always_comb begin
    s_axis_tready = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    prod_load     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      kso_pkg::ST_IDLE: s_axis_tready = 1'b1;
      kso_pkg::ST_SCALE: begin
        mul_a     = kso_pkg::MUL_A_W'(mag);
        mul_b     = kso_pkg::MUL_B_W'(volume_q);
        prod_load = 1'b1;
      end
      kso_pkg::ST_ENV: begin
        mul_a     = prod_q[kso_pkg::MUL_A_W-1:0];
        mul_b     = kso_pkg::MUL_B_W'(env_q);
        prod_load = 1'b1;
      end
      kso_pkg::ST_DIV: begin
        mul_a     = kso_pkg::MUL_A_W'(quot_in);
        mul_b     = kso_pkg::RECIP3;
        prod_load = 1'b1;
      end
      kso_pkg::ST_OUT: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign prod_d = kso_pkg::PROD_W'(mul_a) * kso_pkg::PROD_W'(mul_b);

  always_ff @(posedge clk_i) begin
    if (prod_load) begin
      prod_q <= prod_d;
    end
  end

  assign q = prod_q[kso_pkg::RECIP_SHIFT +: kso_pkg::Q_W];

  always_comb begin
    if (neg_q) begin
      q_sat = (q > kso_pkg::NEG_MAX) ? kso_pkg::NEG_MAX : q;
      res   = kso_pkg::SAMPLE_W'(kso_pkg::Q_W'(0) - q_sat);
    end else begin
      q_sat = (q > kso_pkg::POS_MAX) ? kso_pkg::POS_MAX : q;
      res   = q_sat[kso_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q   <= res;
      out_active_q <= active_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_active_q;

endmodule

[src/kso_checker.sv]
// Port-level checks of the keyed sidetone oscillator and the bind that
// attaches them. Depends on kso_pkg and keyed_sidetone_oscillator_macros.svh.
`include "keyed_sidetone_oscillator_macros.svh"

module kso_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  logic sample_beat;
  logic key_beat;
  logic out_stall;

  assign sample_beat = s_axis_tvalid && s_axis_tready &&
                       (s_axis_tuser[0] == kso_pkg::CMD_SAMPLE);
  assign key_beat    = s_axis_tvalid && s_axis_tready &&
                       (s_axis_tuser[0] == kso_pkg::CMD_KEY);
  assign out_stall   = m_axis_tvalid && !m_axis_tready;

  // A stalled result beat stays valid and holds its value.
  `KSO_ASSERT_NEXT(a_out_hold, out_stall, $stable({m_axis_tvalid, m_axis_tdata, m_axis_tuser}))

  // A sample tick occupies the multiplier, so the input closes behind it.
  `KSO_ASSERT_NEXT(a_busy_after_sample, sample_beat, !s_axis_tready)

  // A key event never creates a result beat.
  `KSO_ASSERT_NEXT(a_key_no_result, key_beat && !m_axis_tvalid, !m_axis_tvalid)

  // Configuration writes are never refused.
  `KSO_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind keyed_sidetone_oscillator kso_checker u_kso_checker (.*);

[tb/sv/kso_tone_checker.sv]
// Checker for the keyed sidetone oscillator: watches the input, output and register
// write channels, predicts every sample beat and compares it field by field.
// Depends on kso_pkg for widths, the fade, command and register codes.
module kso_tone_checker
  import kso_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            in_data_i,
  input  logic [0:0]            in_user_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [SAMPLE_W-1:0]   out_data_i,
  input  logic [0:0]            out_user_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                active;
  } tone_beat_t;

  logic [SAMPLE_W-1:0] quarter_sine [ROM_DEPTH];

  logic [PHASE_W-1:0] step_reg;
  logic [VOL_W-1:0]   vol_reg;
  logic               enable_reg;
  logic [PHASE_W-1:0] tone_phase;
  fade_e              fade;
  logic [ENV_W-1:0]   fade_cnt;
  logic               key_down;

  tone_beat_t expected_beats[$];
  int         mismatches = 0;
  int         outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = outstanding;

  function automatic logic [SAMPLE_W-1:0] sine_entry(int unsigned k);
    longint unsigned x, x2, term, sum, v;
    x    = (64'd1686629713 * 64'(k)) >> TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? SAMPLE_W'(32767) : v[SAMPLE_W-1:0];
  endfunction

  initial begin
    for (int unsigned k = 0; k < ROM_DEPTH; k++) begin
      quarter_sine[TABLE_BITS'(k)] = sine_entry(k);
    end
  end

  function automatic void key_event(logic key_bit);
    if (key_bit != key_down) begin
      key_down = key_bit;
      fade     = key_bit ? FADE_IN : FADE_DOWN;
      fade_cnt = '0;
      if (key_bit) begin
        tone_phase = '0;
      end
    end
  endfunction

  function automatic tone_beat_t render_sample();
    logic [1:0]            quad;
    logic [TABLE_BITS-1:0] idx;
    longint unsigned       mag, env, denom, q;
    tone_beat_t            beat;
    quad = tone_phase[PHASE_W-1 -: 2];
    idx  = tone_phase[PHASE_W-3 -: TABLE_BITS];
    if (quad[0]) begin
      mag = (idx == '0) ? 64'd32767 :
            64'(quarter_sine[TABLE_BITS'(ROM_DEPTH - 32'(idx))]);
    end else begin
      mag = 64'(quarter_sine[idx]);
    end
    case (fade)
      FADE_IN: begin
        env      = 64'(fade_cnt);
        fade_cnt = fade_cnt + 1'b1;
        if (fade_cnt >= ENV_W'(FADE_LEN)) begin
          fade = FADE_FULL;
        end
      end
      FADE_DOWN: begin
        env      = (fade_cnt < ENV_W'(FADE_LEN)) ? 64'(FADE_LEN - fade_cnt) : 64'd0;
        fade_cnt = fade_cnt + 1'b1;
        if (fade_cnt >= ENV_W'(FADE_LEN)) begin
          fade = FADE_IDLE;
          env  = 64'd0;
        end
      end
      FADE_FULL: env = 64'(FADE_LEN);
      default:   env = 64'd0;
    endcase
    denom = 64'(FADE_LEN) << 15;
    q     = (mag * 64'(vol_reg) * env + denom / 2) / denom;
    if (quad[1]) begin
      if (q > 64'd32768) begin
        q = 64'd32768;
      end
      beat.sample = SAMPLE_W'(64'd0 - q);
    end else begin
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      beat.sample = SAMPLE_W'(q);
    end
    beat.active = key_down & enable_reg;
    tone_phase  = tone_phase + step_reg;
    return beat;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tone_beat_t want;
    if (!rst_ni) begin
      step_reg   = '0;
      vol_reg    = '0;
      enable_reg = 1'b0;
      tone_phase = '0;
      fade       = FADE_IDLE;
      fade_cnt   = '0;
      key_down   = 1'b0;
      expected_beats.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          $error("output beat with no sample pending: sample_out %0d, active %0b",
                 $signed(out_data_i), out_user_i[0]);
        end else begin
          want = expected_beats.pop_front();
          if (out_data_i !== want.sample) begin
            mismatches++;
            $error("sample_out: expected %0d, actual %0d",
                   $signed(want.sample), $signed(out_data_i));
          end
          if (out_user_i[0] !== want.active) begin
            mismatches++;
            $error("active: expected %0b, actual %0b", want.active, out_user_i[0]);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_PHASE_STEP: step_reg   = cfg_data_i[PHASE_W-1:0];
          CFG_VOLUME:     vol_reg    = cfg_data_i[VOL_W-1:0];
          CFG_ENABLE:     enable_reg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_e'(in_user_i[0]) == CMD_KEY) begin
          key_event(in_data_i[0]);
        end else begin
          expected_beats.push_back(render_sample());
        end
      end
    end
    outstanding = expected_beats.size();
  end

endmodule

[tb/sv/testbench.sv]
// Top of the keyed sidetone oscillator testbench: clock, reset, keying and sample
// stimulus, register programming, output stalls, watchdog and verdict.
// Depends on kso_pkg, keyed_sidetone_oscillator and kso_tone_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kso_pkg::*;

  localparam int unsigned PHASE_ITEMS   = 115;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned IDLE_LIMIT    = 3000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SLOW,
    RX_BUSY
  } rx_style_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int          mismatches;
  int          pending;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  rx_style_e   rx_style = RX_FREE;
  int unsigned rx_left = 0;

  keyed_sidetone_oscillator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  kso_tone_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_user_i        (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .out_user_i       (m_axis_tuser),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_left  <= $urandom_range(16, 96);
      rx_style <= rx_style_e'($urandom_range(0, 3));
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      RX_FREE: m_axis_tready <= 1'b1;
      RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SLOW: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(cmd_e kind, logic key_bit);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, key_bit};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_samples(int unsigned count);
    repeat (count) send_item(CMD_SAMPLE, 1'($urandom()));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(logic [PHASE_W-1:0] step, logic [VOL_W-1:0] vol, logic en);
    int unsigned first;
    cfg_e        which;
    first = $urandom_range(0, 2);
    for (int unsigned i = 0; i < 3; i++) begin
      which = cfg_e'((first + i) % 3);
      case (which)
        CFG_PHASE_STEP: cfg_write(which, step);
        CFG_VOLUME:     cfg_write(which, {16'($urandom()), vol});
        default:        cfg_write(which, {31'($urandom()), en});
      endcase
    end
    if ($urandom_range(0, 2) == 0) begin
      cfg_write(CFG_SPARE, $urandom());
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic key_burst();
    send_item(CMD_KEY, 1'b1);
    send_samples($urandom_range(0, 72));
    if ($urandom_range(0, 4) == 0) begin
      send_item(CMD_KEY, 1'b1);
    end
    send_item(CMD_KEY, 1'b0);
    send_samples($urandom_range(0, 60));
    if ($urandom_range(0, 4) == 0) begin
      send_item(CMD_KEY, 1'b0);
    end
  endtask

  initial begin
    logic [PHASE_W-1:0] step;
    logic [VOL_W-1:0]   vol;
    logic               en;
    int unsigned        phase_start;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(CMD_SAMPLE, 1'b0);
    send_item(CMD_KEY, 1'b0);
    send_item(CMD_SAMPLE, 1'b1);
    drain();
    program_regs(32'h0400_0000, 16'h8000, 1'b1);
    send_item(CMD_KEY, 1'b1);
    send_samples(4);
    send_item(CMD_KEY, 1'b1);
    send_item(CMD_SAMPLE, 1'b1);
    send_item(CMD_KEY, 1'b0);
    send_samples(3);
    send_item(CMD_KEY, 1'b0);
    send_item(CMD_SAMPLE, 1'b0);
    send_item(CMD_KEY, 1'b1);
    send_samples(3);
    drain();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin step = '1;            vol = '1;       en = 1'b1; end
        1: begin step = '0;            vol = '0;       en = 1'b0; end
        2: begin step = 32'h8000_0000; vol = 16'h8000; en = 1'b1; end
        3: begin step = 32'h4000_0000; vol = 16'h8000; en = 1'b1; end
        4: begin step = 32'h0010_0000; vol = 16'h7FFF; en = 1'b1; end
        default: begin
          step = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 22);
          case ($urandom_range(0, 3))
            0:       vol = 16'h8000;
            1:       vol = 16'($urandom_range(0, 32768));
            2:       vol = 16'($urandom());
            default: vol = 16'($urandom_range(0, 255));
          endcase
          en = ($urandom_range(0, 3) != 0);
        end
      endcase
      program_regs(step, vol, en);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          key_burst();
        end else begin
          repeat ($urandom_range(1, 8)) begin
            send_item(cmd_e'($urandom_range(0, 1)), 1'($urandom()));
          end
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[keyed_sidetone_oscillator.f]
+incdir+src
src/kso_pkg.sv
src/keyed_sidetone_oscillator.sv
src/kso_checker.sv
tb/sv/kso_tone_checker.sv
tb/sv/testbench.sv
